// ===== rtl/btc_pkg.sv =====
`default_nettype none

package btc_pkg;

    localparam int unsigned DEF_MAX_BLOCK = 16;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_CFG_W  = 5;
    localparam int unsigned KEY_W      = 4;
    localparam int unsigned KEY_TBL_W  = 64;
    localparam int unsigned SEED_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [SEED_W-1:0] LFSR_MASK = 16'hB400;
    localparam logic [BYTE_W-1:0] PAD_BASE  = 8'd97;
    localparam int unsigned       PAD_SPAN  = 26;
    // ceil(2^21 / 26): exact quotient for any 16-bit value after a shift by 21
    localparam int unsigned       RECIP_SHIFT = 21;
    localparam logic [16:0]       PAD_RECIP   = 17'd80660;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 2'd0,
        REG_BLOCK_LEN = 2'd1,
        REG_KEY_TABLE = 2'd2,
        REG_PAD_SEED  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_PAD,
        ST_SCATTER,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic store_wr;
        logic pad_wr;
        logic scat_wr;
        logic drain_ld;
        logic idx_clr;
        logic idx_inc;
        logic idx_from_count;
        logic src_clr;
        logic blk_clr;
    } cmd_t;

    typedef struct packed {
        logic blk_done;
        logic count_full;
        logic mode_dec;
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/block_transposition_cipher.sv =====
`default_nettype none

// Channel   Dir  Signals                      Contents
// s_*       in   tvalid tready tdata tlast    message byte, tlast = end of message
// m_*       out  tvalid tready tdata tuser    transposed byte, tuser = fill flags,
//                tlast                        tlast = last byte of the block
// cfg_*     in   valid ready index data       register writes, always ready
//
// Bytes of a block are taken one per cycle while the block fills.
// When a block completes, input stalls: encrypt writes pad letters into the empty
// positions of a short block (one LFSR step each), decrypt builds the scatter map
// over all L positions; then the block drains through the output register, one load
// per position, held while m_tready stalls. The next byte is taken once the last drain load is done.
// Reset leaves the block empty; no clearing pass is needed.
module block_transposition_cipher #(
    parameter int unsigned MAX_BLOCK = btc_pkg::DEF_MAX_BLOCK
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] data_byte
    input  wire logic                               s_tlast,   // end_of_message
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [7:0]                              m_tdata,   // [7:0] out_byte
    output logic [1:0]                              m_tuser,   // [0] is_fill, [1] message_last
    output logic                                    m_tlast,   // block_last
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [btc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [btc_pkg::KEY_TBL_W-1:0]      cfg_data
);

    btc_pkg::cmd_t    cmd;
    btc_pkg::status_t st;
    logic             is_fill;
    logic             msg_last;

    assign cfg_ready = 1'b1;

    btc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    btc_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_byte          (s_tdata),
        .in_eom           (s_tlast),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .st               (st),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_byte         (m_tdata),
        .out_is_fill      (is_fill),
        .out_block_last   (m_tlast),
        .out_message_last (msg_last)
    );

    assign m_tuser = {msg_last, is_fill};

endmodule

`default_nettype wire

// ===== rtl/btc_ctrl.sv =====
`default_nettype none

module btc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire btc_pkg::status_t st,
    output btc_pkg::cmd_t         cmd
);

    btc_pkg::state_t state_reg;
    btc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btc_pkg::ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            btc_pkg::ST_FILL:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store_wr = 1'b1;
                    if (st.blk_done)
                    begin
                        if (st.mode_dec)
                        begin
                            cmd.idx_clr = 1'b1;
                            cmd.src_clr = 1'b1;
                            state_next  = btc_pkg::ST_SCATTER;
                        end
                        else if (st.count_full)
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = btc_pkg::ST_DRAIN;
                        end
                        else
                        begin
                            // pad from the first empty position up
                            cmd.idx_from_count = 1'b1;
                            state_next         = btc_pkg::ST_PAD;
                        end
                    end
                end
            end
            btc_pkg::ST_PAD:
            begin
                cmd.pad_wr = 1'b1;
                if (st.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = btc_pkg::ST_DRAIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            btc_pkg::ST_SCATTER:
            begin
                cmd.scat_wr = 1'b1;
                if (st.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = btc_pkg::ST_DRAIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            btc_pkg::ST_DRAIN:
            begin
                if (st.out_free)
                begin
                    cmd.drain_ld = 1'b1;
                    if (st.idx_last)
                    begin
                        cmd.idx_clr = 1'b1;
                        cmd.blk_clr = 1'b1;
                        state_next  = btc_pkg::ST_FILL;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = btc_pkg::ST_FILL;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/btc_dp.sv =====
`default_nettype none

module btc_dp #(
    parameter int unsigned MAX_BLOCK = btc_pkg::DEF_MAX_BLOCK
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [btc_pkg::BYTE_W-1:0]            in_byte,
    input  wire logic                                  in_eom,
    input  wire logic                                  cfg_valid,
    input  wire logic [btc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [btc_pkg::KEY_TBL_W-1:0]         cfg_data,
    input  wire btc_pkg::cmd_t                         cmd,
    output btc_pkg::status_t                           st,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic [btc_pkg::BYTE_W-1:0]                 out_byte,
    output logic                                       out_is_fill,
    output logic                                       out_block_last,
    output logic                                       out_message_last
);

    localparam int unsigned IW = $clog2(MAX_BLOCK);
    localparam int unsigned LW = $clog2(MAX_BLOCK + 1);
    localparam int unsigned EW = btc_pkg::LEN_CFG_W;

    // configuration
    logic                              mode_reg;
    logic [btc_pkg::LEN_CFG_W-1:0]     block_len_reg;
    logic [btc_pkg::KEY_TBL_W-1:0]     key_reg;
    logic [btc_pkg::SEED_W-1:0]        lfsr_reg;
    logic [btc_pkg::SEED_W-1:0]        lfsr_next;

    // block state
    logic [LW-1:0]                     fill_count_reg;
    logic                              eom_reg;
    logic [IW-1:0]                     idx_reg;
    logic [MAX_BLOCK-1:0]              src_vld_reg;
    logic [IW-1:0]                     src_reg [MAX_BLOCK];
    logic [btc_pkg::BYTE_W-1:0]        store_reg [MAX_BLOCK];

    // output register
    logic                              out_valid_reg;
    logic [btc_pkg::BYTE_W-1:0]        out_byte_reg;
    logic                              out_fill_reg;
    logic                              out_blast_reg;
    logic                              out_mlast_reg;

    logic [LW-1:0]                     len;
    logic [LW-1:0]                     pos;
    logic [LW-1:0]                     count_new;
    logic                              idx_last;
    logic [btc_pkg::KEY_W-1:0]         key_cur;
    logic                              key_ok;
    logic [32:0]                       quo_prod;
    logic [11:0]                       quo;
    logic [btc_pkg::SEED_W-1:0]        quo_x26;
    logic [btc_pkg::SEED_W-1:0]        rem16;
    logic [btc_pkg::BYTE_W-1:0]        pad_byte;
    logic [IW-1:0]                     rd_addr;
    logic [btc_pkg::BYTE_W-1:0]        drain_byte;
    logic                              drain_fill;
    logic                              src_ok;

    always_comb
    begin
        if (block_len_reg == '0)
        begin
            len = LW'(1);
        end
        else if (block_len_reg > EW'(MAX_BLOCK))
        begin
            len = LW'(MAX_BLOCK);
        end
        else
        begin
            len = block_len_reg[LW-1:0];
        end
    end

    // a shortened block length clamps the write position to the last slot
    assign pos       = (fill_count_reg >= len) ? len - LW'(1) : fill_count_reg;
    assign count_new = pos + LW'(1);
    assign idx_last  = ((LW'(idx_reg) + LW'(1)) == len);

    assign key_cur = key_reg[idx_reg * btc_pkg::KEY_W +: btc_pkg::KEY_W];
    assign key_ok  = (EW'(key_cur) < EW'(len));

    // step the Galois LFSR, then reduce mod 26 by reciprocal multiply
    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? btc_pkg::LFSR_MASK : '0);
    assign quo_prod  = 33'(lfsr_next) * 33'(btc_pkg::PAD_RECIP);
    assign quo       = quo_prod[btc_pkg::RECIP_SHIFT +: 12];
    assign quo_x26   = (16'(quo) << 4) + (16'(quo) << 3) + (16'(quo) << 1);
    assign rem16     = lfsr_next - quo_x26;
    assign pad_byte  = btc_pkg::PAD_BASE + 8'(rem16[4:0]);

    assign src_ok = src_vld_reg[idx_reg] && (LW'(src_reg[idx_reg]) < fill_count_reg);

    always_comb
    begin
        rd_addr    = '0;
        drain_fill = 1'b1;
        if (mode_reg)
        begin
            rd_addr    = src_reg[idx_reg];
            drain_fill = !src_ok;
        end
        else
        begin
            rd_addr    = key_cur[IW-1:0];
            drain_fill = !key_ok || (EW'(key_cur) >= EW'(fill_count_reg));
        end
    end

    // missing or out-of-range positions read as zero; pad letters keep their value
    always_comb
    begin
        if (mode_reg ? src_ok : key_ok)
        begin
            drain_byte = store_reg[rd_addr];
        end
        else
        begin
            drain_byte = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            block_len_reg <= 5'd16;
            key_reg       <= '0;
            lfsr_reg      <= 16'd1;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (btc_pkg::cfg_reg_t'(cfg_index))
                    btc_pkg::REG_MODE:      mode_reg      <= cfg_data[0];
                    btc_pkg::REG_BLOCK_LEN: block_len_reg <= cfg_data[btc_pkg::LEN_CFG_W-1:0];
                    btc_pkg::REG_KEY_TABLE: key_reg       <= cfg_data;
                    btc_pkg::REG_PAD_SEED:
                    begin
                        // a zero seed would lock the LFSR
                        lfsr_reg <= (cfg_data[btc_pkg::SEED_W-1:0] == '0) ?
                                    16'd1 : cfg_data[btc_pkg::SEED_W-1:0];
                    end
                    default: ;
                endcase
            end
            else if (cmd.pad_wr)
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            eom_reg        <= 1'b0;
            idx_reg        <= '0;
            src_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.blk_clr)
            begin
                fill_count_reg <= '0;
            end
            else if (cmd.store_wr)
            begin
                fill_count_reg <= count_new;
                eom_reg        <= in_eom;
            end

            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_from_count)
            begin
                idx_reg <= count_new[IW-1:0];
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IW'(1);
            end

            if (cmd.src_clr)
            begin
                src_vld_reg <= '0;
            end
            else if (cmd.scat_wr && key_ok)
            begin
                src_vld_reg[key_cur[IW-1:0]] <= 1'b1;
            end

            if (cmd.drain_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_wr)
        begin
            store_reg[pos[IW-1:0]] <= in_byte;
        end
        else if (cmd.pad_wr)
        begin
            store_reg[idx_reg] <= pad_byte;
        end

        // later source index overwrites: highest one wins
        if (cmd.scat_wr && key_ok)
        begin
            src_reg[key_cur[IW-1:0]] <= idx_reg;
        end

        if (cmd.drain_ld)
        begin
            out_byte_reg  <= drain_byte;
            out_fill_reg  <= drain_fill;
            out_blast_reg <= idx_last;
            out_mlast_reg <= idx_last && eom_reg;
        end
    end

    assign st.blk_done   = (count_new >= len) || in_eom;
    assign st.count_full = (count_new >= len);
    assign st.mode_dec   = mode_reg;
    assign st.idx_last   = idx_last;
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_byte         = out_byte_reg;
    assign out_is_fill      = out_fill_reg;
    assign out_block_last   = out_blast_reg;
    assign out_message_last = out_mlast_reg;

endmodule

`default_nettype wire

// ===== dv/btc_checker.sv =====
`default_nettype none

module btc_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tlast,   // end_of_message
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [7:0]                    m_tdata,   // [7:0] out_byte
    input  wire logic [1:0]                    m_tuser,   // [0] is_fill, [1] message_last
    input  wire logic                          m_tlast,   // block_last
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          end_of_test,
    output int                                 pending,
    output int                                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import btc_pkg::*;

    localparam int unsigned NBLK      = 16;
    localparam logic [15:0] PAD_TAPS  = 16'hB400;
    localparam logic [7:0]  PAD_LOW   = 8'd97;
    localparam int          MAX_SHOWN = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_fill;
        logic       block_last;
        logic       message_last;
    } cipher_out_t;

    logic        mode_dec;
    logic [4:0]  len_cfg;
    logic [63:0] key_tbl;
    logic [15:0] pad_state;
    logic [7:0]  blk [NBLK];
    int unsigned fill_cnt;

    cipher_out_t cipher_bytes_q [$];
    int          mismatches;
    bit          closed;

    function automatic int unsigned active_len();
        if (len_cfg == 5'd0)
            return 1;
        if (len_cfg > 5'(NBLK))
            return NBLK;
        return int'(len_cfg);
    endfunction

    function automatic int unsigned key_entry(int unsigned j);
        return int'(key_tbl[4*j +: 4]);
    endfunction

    // Galois step, shift right, then map into 'a'..'z'
    task automatic pad_letter(output logic [7:0] letter);
        logic lsb;
        lsb = pad_state[0];
        pad_state = pad_state >> 1;
        if (lsb)
            pad_state = pad_state ^ PAD_TAPS;
        letter = PAD_LOW + 8'(pad_state % 16'd26);
    endtask

    task automatic absorb_byte(input logic [7:0] d, input logic eom);
        int unsigned L;
        int unsigned pos;
        int unsigned cnt;
        int unsigned k;
        logic [7:0]  padded [NBLK];
        logic [7:0]  val [NBLK];
        logic        flag [NBLK];
        int          src [NBLK];
        cipher_out_t r;
        L = active_len();
        pos = fill_cnt;
        // a shortened block overwrites its last position
        if (pos >= L)
            pos = L - 1;
        blk[pos] = d;
        cnt = pos + 1;
        if (cnt < L && !eom) begin
            fill_cnt = cnt;
            return;
        end
        if (!mode_dec) begin
            for (int unsigned p = 0; p < L; p++) begin
                if (p < cnt)
                    padded[p] = blk[p];
                else
                    pad_letter(padded[p]);
            end
            for (int unsigned j = 0; j < L; j++) begin
                k = key_entry(j);
                if (k < L) begin
                    val[j] = padded[k];
                    flag[j] = (k >= cnt);
                end
                else begin
                    val[j] = 8'h00;
                    flag[j] = 1'b1;
                end
            end
        end
        else begin
            for (int unsigned p = 0; p < L; p++)
                src[p] = -1;
            // later key entries win on repeats
            for (int unsigned j = 0; j < L; j++) begin
                k = key_entry(j);
                if (k < L)
                    src[k] = int'(j);
            end
            for (int unsigned p = 0; p < L; p++) begin
                if (src[p] >= 0 && src[p] < int'(cnt)) begin
                    val[p] = blk[src[p]];
                    flag[p] = 1'b0;
                end
                else begin
                    val[p] = 8'h00;
                    flag[p] = 1'b1;
                end
            end
        end
        for (int unsigned j = 0; j < L; j++) begin
            r.out_byte = val[j];
            r.is_fill = flag[j];
            r.block_last = (j + 1 == L);
            r.message_last = (j + 1 == L) && eom;
            cipher_bytes_q.push_back(r);
        end
        fill_cnt = 0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        cipher_out_t want;
        cipher_out_t got;
        if (!rst_n) begin
            mode_dec = 1'b0;
            len_cfg = 5'd16;
            key_tbl = '0;
            pad_state = 16'd1;
            for (int i = 0; i < NBLK; i++)
                blk[i] = 8'h00;
            fill_cnt = 0;
            cipher_bytes_q.delete();
            mismatches = 0;
            closed = 1'b0;
            pending <= 0;
            fail_count <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got = cipher_out_t'({m_tdata, m_tuser[0], m_tlast, m_tuser[1]});
                if (cipher_bytes_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected output byte %02h fill %0b blast %0b mlast %0b",
                                 got.out_byte, got.is_fill, got.block_last, got.message_last);
                end
                else begin
                    want = cipher_bytes_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"mismatch: expected byte %02h fill %0b blast %0b mlast %0b,",
                                      " got byte %02h fill %0b blast %0b mlast %0b"},
                                     want.out_byte, want.is_fill, want.block_last,
                                     want.message_last, got.out_byte, got.is_fill,
                                     got.block_last, got.message_last);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MODE:      mode_dec = cfg_data[0];
                    REG_BLOCK_LEN: len_cfg = cfg_data[4:0];
                    REG_KEY_TABLE: key_tbl = cfg_data;
                    REG_PAD_SEED:  pad_state = (cfg_data[15:0] == 16'd0) ? 16'd1
                                                                         : cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
            if (end_of_test && !closed) begin
                closed = 1'b1;
                if (cipher_bytes_q.size() != 0) begin
                    $display("%0d expected output bytes never arrived", cipher_bytes_q.size());
                    mismatches += cipher_bytes_q.size();
                end
            end
            pending <= cipher_bytes_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

`default_nettype wire

// ===== dv/block_transposition_cipher_test.sv =====
`default_nettype none

module block_transposition_cipher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import btc_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE       = 40;
    localparam int TARGET_ITEMS = 310;
    localparam int HOLD_CYCLES  = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    int          hold_len = 0;
    logic        end_of_test = 1'b0;
    int          pending;
    int          fail_count;
    int          bytes_sent = 0;
    int          reg_writes = 0;
    int          phases = 0;
    int          quiet = 0;
    int unsigned cur_len = 16;

    always #5 clk = ~clk;

    block_transposition_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    btc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .end_of_test (end_of_test),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
                $display("FAIL block_transposition_cipher");
                $finish;
            end
        end
    end

    // receiver: random back-pressure bursts, plus one long hold on request
    initial begin : rx_side
        int n;
        forever begin
            if (hold_len > 0) begin
                n = hold_len;
                hold_len = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic eom);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= eom;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_message(input int n, input bit close);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), close && (i == n - 1));
    endtask

    // drop valid, drain every expected byte, then let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
    endtask

    task automatic apply_setting(input bit [3:0] sel, input logic m, input logic [4:0] len,
                                 input logic [63:0] key, input logic [15:0] seed);
        settle();
        if (sel[REG_MODE])
            write_reg(REG_MODE, 64'(m));
        if (sel[REG_BLOCK_LEN]) begin
            write_reg(REG_BLOCK_LEN, 64'(len));
            cur_len = (len == 5'd0) ? 1 : (len > 5'd16) ? 16 : int'(len);
        end
        if (sel[REG_KEY_TABLE])
            write_reg(REG_KEY_TABLE, key);
        if (sel[REG_PAD_SEED])
            write_reg(REG_PAD_SEED, 64'(seed));
        cfg_valid <= 1'b0;
    endtask

    // first len entries form a permutation of 0..len-1, the rest are noise
    function automatic logic [63:0] perm_key(input int unsigned len);
        logic [3:0]  ent [16];
        logic [3:0]  t;
        logic [63:0] key;
        int unsigned r;
        for (int i = 0; i < 16; i++)
            ent[i] = (i < len) ? 4'(i) : 4'($urandom);
        for (int i = int'(len) - 1; i > 0; i--) begin
            r = $urandom_range(0, i);
            t = ent[i];
            ent[i] = ent[r];
            ent[r] = t;
        end
        for (int i = 0; i < 16; i++)
            key[4*i +: 4] = ent[i];
        return key;
    endfunction

    initial begin
        bit [3:0]    sel;
        logic [4:0]  len;
        int unsigned pick;
        int          nmsg;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reversed key, padded short block then full block
        apply_setting(4'b1111, 1'b0, 5'd4, 64'h0123, 16'hACE1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        // repeated and out-of-range key entries, decrypt then encrypt
        apply_setting(4'b0101, 1'b1, 5'd4, 64'hF115, 16'h0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h7E, 1'b1);
        apply_setting(4'b0001, 1'b0, 5'd4, 64'h0, 16'h0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h18, 1'b1);
        // zero length and zero seed
        apply_setting(4'b1110, 1'b0, 5'd0, 64'h0, 16'h0000);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        // shrink the block under a partial fill
        apply_setting(4'b0110, 1'b0, 5'd8, 64'h120, 16'h0);
        send_message(5, 1'b0);
        apply_setting(4'b0010, 1'b0, 5'd3, 64'h0, 16'h0);
        send_byte(8'hE7, 1'b0);
        // flip mode under a partial fill
        apply_setting(4'b0110, 1'b0, 5'd2, 64'h01, 16'h0);
        send_byte(8'h96, 1'b0);
        apply_setting(4'b0001, 1'b1, 5'd2, 64'h0, 16'h0);
        send_byte(8'h69, 1'b1);
        // oversized length clamps to the maximum, identity key
        apply_setting(4'b0110, 1'b1, 5'd31, 64'hFEDCBA9876543210, 16'h0);
        send_message(4, 1'b1);

        while (bytes_sent < TARGET_ITEMS) begin
            phases++;
            if (bytes_sent >= TARGET_ITEMS - 60) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 12)
                len = 5'($urandom_range(1, 8));
            else if (pick < 16)
                len = 5'($urandom_range(9, 16));
            else if (pick < 18)
                len = 5'd16;
            else
                len = 5'($urandom_range(0, 31));
            if (phases == 3) begin
                // long output stall with the sender still pushing
                apply_setting(4'b0110, 1'b0, 5'd16, perm_key(16), 16'h0);
                hold_len = HOLD_CYCLES;
                send_message(48, 1'b1);
            end
            else begin
                sel = (phases == 1) ? 4'b1111 : 4'($urandom_range(1, 15));
                apply_setting(sel, 1'($urandom), len,
                              ($urandom_range(0, 3) != 0) ?
                                  perm_key((len == 0) ? 1 : (len > 16) ? 16 : int'(len))
                                  : {$urandom, $urandom},
                              ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
                nmsg = $urandom_range(1, 3);
                for (int i = 0; i < nmsg; i++)
                    send_message($urandom_range(1, 2 * cur_len + 3),
                                 $urandom_range(0, 9) != 0);
            end
        end

        settle();
        end_of_test <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        $display("sent %0d message bytes over %0d random phases with %0d register writes",
                 bytes_sent, phases, reg_writes);
        $display("both modes, lengths 0 to 31, padding, dropped keys and a long output stall");
        if (fail_count == 0)
            $display("PASS block_transposition_cipher");
        else
            $display("FAIL block_transposition_cipher");
        $finish;
    end

endmodule

`default_nettype wire

// ===== block_transposition_cipher.f =====
rtl/btc_pkg.sv
rtl/btc_ctrl.sv
rtl/btc_dp.sv
rtl/block_transposition_cipher.sv
dv/btc_checker.sv
dv/block_transposition_cipher_test.sv
